/* rtl/indexed_insert_delete_array_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the indexed insert/delete array
// Shorthand for clocked concurrent checks that are disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_INSERT_DELETE_ARRAY_ASSERT_SVH
`define INDEXED_INSERT_DELETE_ARRAY_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define IIDA_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define IIDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define IIDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/iida_pkg.sv */
// ----------------------------------------------------------------------------
// iida_pkg: shared types and constants
// Field widths, operation and status codes, cell chain control and FSM states.
// ----------------------------------------------------------------------------
package iida_pkg;

    // Field widths of the input and result beats.
    localparam int DATA_W  = 32;
    localparam int OP_W    = 2;
    localparam int IDX_W   = 7;
    localparam int STAT_W  = 3;
    localparam int FOUND_W = 6;
    localparam int COUNT_W = 7;

    // Default number of cells in the chain.
    localparam int CAPACITY_DEF = 64;

    typedef enum logic [OP_W-1:0] {
        OP_READ   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_SEARCH = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_BAD_INDEX = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    // Command broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        CH_HOLD   = 2'd0,
        CH_INSERT = 2'd1,
        CH_DELETE = 2'd2,
        CH_ROTATE = 2'd3
    } chain_op_t;

    typedef struct packed {
        chain_op_t        op;
        logic [IDX_W-1:0] idx;
    } chain_ctl_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_SHIFT  = 2'd2,
        S_FINISH = 2'd3
    } fsm_state_t;

endpackage

/* rtl/iida_cell.sv */
// ----------------------------------------------------------------------------
// iida_cell: one storage cell of the entry chain
// Holds one entry and loads from its neighbors, the insert value, or itself.
// ----------------------------------------------------------------------------
module iida_cell #(
    parameter int CAPACITY = iida_pkg::CAPACITY_DEF,
    parameter int CELL_POS = 0
) (
    input  logic                                clk,
    input  iida_pkg::chain_ctl_t                ctl,
    input  logic signed [iida_pkg::DATA_W-1:0]  ins_value,
    input  logic signed [iida_pkg::DATA_W-1:0]  prev_entry,
    input  logic signed [iida_pkg::DATA_W-1:0]  next_entry,
    output logic signed [iida_pkg::DATA_W-1:0]  entry
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CW    = (iida_pkg::IDX_W > PTR_W) ? iida_pkg::IDX_W : PTR_W;

    logic [CW-1:0]                        pos;
    logic [CW-1:0]                        idx_ext;
    logic signed [iida_pkg::DATA_W-1:0]   entry_reg;
    logic signed [iida_pkg::DATA_W-1:0]   entry_next;

    assign pos     = CW'(CELL_POS);
    assign idx_ext = CW'(ctl.idx);
    assign entry   = entry_reg;

    // Select the new content of this cell from the broadcast command.
    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.op)
            iida_pkg::CH_INSERT:
            begin
                if (pos > idx_ext)
                begin
                    entry_next = prev_entry;
                end
                else if (pos == idx_ext)
                begin
                    entry_next = ins_value;
                end
            end
            iida_pkg::CH_DELETE:
            begin
                if (pos >= idx_ext)
                begin
                    entry_next = next_entry;
                end
            end
            iida_pkg::CH_ROTATE:
            begin
                entry_next = next_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Entry storage is payload and needs no reset.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* rtl/iida_ctrl.sv */
// ----------------------------------------------------------------------------
// iida_ctrl: sequencer, fill count and result register
// Decodes each beat, drives the cell chain, scans the ring head and stages results.
// ----------------------------------------------------------------------------
`include "indexed_insert_delete_array_assert.svh"

module iida_ctrl #(
    parameter int CAPACITY = iida_pkg::CAPACITY_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [iida_pkg::OP_W-1:0]            operation,
    input  logic signed [iida_pkg::DATA_W-1:0]   value,
    input  logic [iida_pkg::IDX_W-1:0]           index,
    input  logic signed [iida_pkg::DATA_W-1:0]   head_entry,
    output iida_pkg::chain_ctl_t                 chain_ctl,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [iida_pkg::STAT_W-1:0]          status,
    output logic signed [iida_pkg::DATA_W-1:0]   value_out,
    output logic [iida_pkg::FOUND_W-1:0]         found_index,
    output logic [iida_pkg::COUNT_W-1:0]         count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > iida_pkg::IDX_W) ? CNT_W : iida_pkg::IDX_W;

    iida_pkg::fsm_state_t                state_reg;
    iida_pkg::fsm_state_t                state_next;
    logic [CNT_W-1:0]                    fill_count_reg;
    logic [CNT_W-1:0]                    fill_count_next;
    logic [PTR_W-1:0]                    scan_reg;
    iida_pkg::op_t                       op_reg;
    logic signed [iida_pkg::DATA_W-1:0]  val_reg;
    logic [iida_pkg::IDX_W-1:0]          idx_reg;
    logic                                hit_reg;
    iida_pkg::status_t                   res_status_reg;
    logic signed [iida_pkg::DATA_W-1:0]  res_value_reg;
    logic [iida_pkg::FOUND_W-1:0]        res_found_reg;
    logic                                out_valid_reg;
    logic [iida_pkg::STAT_W-1:0]         out_status_reg;
    logic signed [iida_pkg::DATA_W-1:0]  out_value_reg;
    logic [iida_pkg::FOUND_W-1:0]        out_found_reg;
    logic [iida_pkg::COUNT_W-1:0]        out_count_reg;

    logic                                acc;
    logic [CMP_W-1:0]                    cnt_ext;
    logic [CMP_W-1:0]                    idx_ext;
    logic [CMP_W-1:0]                    scan_ext;
    logic [CMP_W-1:0]                    idx_reg_ext;
    logic                                cnt_zero;
    logic                                cnt_full;
    logic                                scan_last;
    logic                                out_free;
    logic                                load_out;
    iida_pkg::op_t                       in_op;
    iida_pkg::status_t                   dec_status;
    logic                                dec_scan;
    logic                                dec_insert;
    logic                                search_hit;
    logic                                pick_hit;

    // Common comparisons; the index, count and scan compares use one extended width.
    assign in_op       = iida_pkg::op_t'(operation);
    assign acc         = in_valid && in_ready;
    assign cnt_ext     = CMP_W'(fill_count_reg);
    assign idx_ext     = CMP_W'(index);
    assign scan_ext    = CMP_W'(scan_reg);
    assign idx_reg_ext = CMP_W'(idx_reg);
    assign cnt_zero    = (fill_count_reg == CNT_W'(0));
    assign cnt_full    = (fill_count_reg == CNT_W'(CAPACITY));
    assign scan_last   = (scan_reg == PTR_W'(CAPACITY - 1));
    assign out_free    = !out_valid_reg || out_ready;
    assign load_out    = (state_reg == iida_pkg::S_FINISH) && out_free;

    // Match at the ring head during a scan: first valid entry equal to the key.
    assign search_hit = (op_reg == iida_pkg::OP_SEARCH) && !hit_reg
                        && (scan_ext < cnt_ext) && (head_entry == val_reg);
    assign pick_hit   = ((op_reg == iida_pkg::OP_READ) || (op_reg == iida_pkg::OP_DELETE))
                        && (scan_ext == idx_reg_ext);

    // Decode the incoming beat against the current fill count.
    always_comb
    begin
        dec_status = iida_pkg::ST_OK;
        dec_scan   = 1'b0;
        dec_insert = 1'b0;
        case (in_op)
            iida_pkg::OP_READ, iida_pkg::OP_DELETE:
            begin
                if (cnt_zero)
                begin
                    dec_status = iida_pkg::ST_EMPTY;
                end
                else if (idx_ext >= cnt_ext)
                begin
                    dec_status = iida_pkg::ST_BAD_INDEX;
                end
                else
                begin
                    dec_scan = 1'b1;
                end
            end
            iida_pkg::OP_INSERT:
            begin
                if (cnt_full)
                begin
                    dec_status = iida_pkg::ST_FULL;
                end
                else if (idx_ext > cnt_ext)
                begin
                    dec_status = iida_pkg::ST_BAD_INDEX;
                end
                else
                begin
                    dec_insert = 1'b1;
                end
            end
            iida_pkg::OP_SEARCH:
            begin
                if (cnt_zero)
                begin
                    dec_status = iida_pkg::ST_EMPTY;
                end
                else
                begin
                    dec_status = iida_pkg::ST_NOT_FOUND;
                    dec_scan   = 1'b1;
                end
            end
            default:
            begin
                dec_status = iida_pkg::ST_OK;
            end
        endcase
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            iida_pkg::S_IDLE:
            begin
                if (acc)
                begin
                    state_next = dec_scan ? iida_pkg::S_SCAN : iida_pkg::S_FINISH;
                end
            end
            iida_pkg::S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = (op_reg == iida_pkg::OP_DELETE) ? iida_pkg::S_SHIFT
                                                                 : iida_pkg::S_FINISH;
                end
            end
            iida_pkg::S_SHIFT:
            begin
                state_next = iida_pkg::S_FINISH;
            end
            iida_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = iida_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = iida_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer outputs: input ready and the chain command.
    always_comb
    begin
        in_ready      = 1'b0;
        chain_ctl.op  = iida_pkg::CH_HOLD;
        chain_ctl.idx = index;
        case (state_reg)
            iida_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (acc && dec_insert)
                begin
                    chain_ctl.op = iida_pkg::CH_INSERT;
                end
            end
            iida_pkg::S_SCAN:
            begin
                chain_ctl.op = iida_pkg::CH_ROTATE;
            end
            iida_pkg::S_SHIFT:
            begin
                chain_ctl.op  = iida_pkg::CH_DELETE;
                chain_ctl.idx = idx_reg;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Fill count moves up on an insert and down on the delete shift.
    always_comb
    begin
        fill_count_next = fill_count_reg;
        if (acc && dec_insert)
        begin
            fill_count_next = fill_count_reg + CNT_W'(1);
        end
        else if (state_reg == iida_pkg::S_SHIFT)
        begin
            fill_count_next = fill_count_reg - CNT_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= iida_pkg::S_IDLE;
            fill_count_reg <= '0;
            scan_reg       <= '0;
            op_reg         <= iida_pkg::OP_READ;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            if (acc)
            begin
                op_reg  <= in_op;
                hit_reg <= 1'b0;
            end
            else if (search_hit && (state_reg == iida_pkg::S_SCAN))
            begin
                hit_reg <= 1'b1;
            end
            if (state_reg == iida_pkg::S_SCAN)
            begin
                scan_reg <= scan_last ? PTR_W'(0) : scan_reg + PTR_W'(1);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Operand latch, result build-up during the scan, and the output register.
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            val_reg        <= value;
            idx_reg        <= index;
            res_status_reg <= dec_status;
            res_value_reg  <= '0;
            res_found_reg  <= '0;
        end
        else if (state_reg == iida_pkg::S_SCAN)
        begin
            if (search_hit)
            begin
                res_status_reg <= iida_pkg::ST_OK;
                res_found_reg  <= iida_pkg::FOUND_W'(scan_reg);
            end
            if (pick_hit)
            begin
                res_value_reg <= head_entry;
            end
        end
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
            out_found_reg  <= res_found_reg;
            out_count_reg  <= iida_pkg::COUNT_W'(fill_count_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign value_out   = out_value_reg;
    assign found_index = out_found_reg;
    assign count       = out_count_reg;

    // Checks on the sequencer and fill count.
    `IIDA_ASSERT_ALWAYS(a_count_bound, clk, rst_n, fill_count_reg <= CNT_W'(CAPACITY), "fill count above capacity")
    `IIDA_ASSERT_IMP(a_scan_idle, clk, rst_n, state_reg != iida_pkg::S_SCAN, scan_reg == PTR_W'(0), "scan pointer left nonzero outside a scan")
    `IIDA_ASSERT_NEXT(a_count_step, clk, rst_n, 1'b1, (fill_count_reg == $past(fill_count_reg)) || (fill_count_reg == $past(fill_count_reg) + CNT_W'(1)) || (fill_count_reg == $past(fill_count_reg) - CNT_W'(1)), "fill count jumped by more than one")
    `IIDA_ASSERT_NEXT(a_result_load, clk, rst_n, load_out, out_valid_reg && (state_reg == iida_pkg::S_IDLE), "staged result not presented")

endmodule

/* rtl/indexed_insert_delete_array.sv */
// ----------------------------------------------------------------------------
// indexed_insert_delete_array: packed array with insert, delete, read and search
// Insert and rejected beats go straight to the result stage; read and search rotate the whole ring first,
// and delete also shifts the chain after its scan. One beat at a time: a new beat is taken only when idle.
// rst_n (async, active low) zeroes the fill count and control state; cells are not reset.
// ----------------------------------------------------------------------------
module indexed_insert_delete_array #(
    parameter int CAPACITY = iida_pkg::CAPACITY_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [iida_pkg::OP_W-1:0]            operation,
    input  logic signed [iida_pkg::DATA_W-1:0]   value,
    input  logic [iida_pkg::IDX_W-1:0]           index,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [iida_pkg::STAT_W-1:0]          status,
    output logic signed [iida_pkg::DATA_W-1:0]   value_out,
    output logic [iida_pkg::FOUND_W-1:0]         found_index,
    output logic [iida_pkg::COUNT_W-1:0]         count
);

    iida_pkg::chain_ctl_t                chain_ctl;
    logic signed [iida_pkg::DATA_W-1:0]  entry_w [CAPACITY];

    // Sequencer, fill count and result register.
    iida_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .value       (value),
        .index       (index),
        .head_entry  (entry_w[0]),
        .chain_ctl   (chain_ctl),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .value_out   (value_out),
        .found_index (found_index),
        .count       (count)
    );

    // Ring of cells; each cell sees its two neighbors, the last wraps to the first.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam int PREV = (i == 0) ? CAPACITY - 1 : i - 1;
        localparam int NEXT = (i == CAPACITY - 1) ? 0 : i + 1;

        iida_cell #(
            .CAPACITY (CAPACITY),
            .CELL_POS (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (chain_ctl),
            .ins_value  (value),
            .prev_entry (entry_w[PREV]),
            .next_entry (entry_w[NEXT]),
            .entry      (entry_w[i])
        );
    end

endmodule
